>>> hdl/ctom_pkg.sv
// Shared types and codes for the corner table opposite matcher.
// No dependencies.
`default_nettype none
package ctom_pkg;

	localparam int FIELD_BITS  = 16;
	localparam int CORNER_BITS = 14;

	// result status codes
	localparam logic [1:0] STATUS_MATCH    = 2'd0;
	localparam logic [1:0] STATUS_FLIPPED  = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_TOO_MANY = 2'd3;

	// edge slot states
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_USED  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	typedef struct packed {
		logic                  new_mesh;
		logic [FIELD_BITS-1:0] vertex_a;
		logic [FIELD_BITS-1:0] vertex_b;
		logic [FIELD_BITS-1:0] vertex_c;
	} tri_item_t;

	typedef struct packed {
		logic [CORNER_BITS-1:0] corner_id;
		logic [CORNER_BITS-1:0] opposite_id;
		logic [1:0]             status;
		logic                   last;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/ctom_if.sv
// Handshake channels for triangle items and result items.
// Depends on ctom_pkg.
`default_nettype none
interface ctom_in_if;
	logic                            valid;
	logic                            ready;
	logic                            new_mesh;
	logic [ctom_pkg::FIELD_BITS-1:0] vertex_a;
	logic [ctom_pkg::FIELD_BITS-1:0] vertex_b;
	logic [ctom_pkg::FIELD_BITS-1:0] vertex_c;
	modport source (output valid, new_mesh, vertex_a, vertex_b, vertex_c, input ready);
	modport sink (input valid, new_mesh, vertex_a, vertex_b, vertex_c, output ready);
endinterface

interface ctom_out_if;
	logic                             valid;
	logic                             ready;
	logic [ctom_pkg::CORNER_BITS-1:0] corner_id;
	logic [ctom_pkg::CORNER_BITS-1:0] opposite_id;
	logic [1:0]                       status;
	logic                             last;
	modport source (output valid, corner_id, opposite_id, status, last, input ready);
	modport sink (input valid, corner_id, opposite_id, status, last, output ready);
endinterface
`default_nettype wire

>>> hdl/ctom_fifo.sv
// Two-entry queue with valid/ready on both sides.
// No package dependencies.
`default_nettype none
module ctom_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	logic [WIDTH-1:0] data_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = data_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			data_q[wr_q] <= push_data;
	end
endmodule
`default_nettype wire

>>> hdl/ctom_engine.sv
// Back end: probes the hashed pending-edge memory corner by corner and builds results.
// Depends on ctom_pkg.
`default_nettype none
module ctom_engine #(
	parameter int MAX_TRIANGLES = 4096,
	parameter int VERTEX_BITS   = 16,
	parameter int EDGE_SLOTS    = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire ctom_pkg::tri_item_t item,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output ctom_pkg::result_t        res,
	output logic                     clearing
);
	localparam int V  = VERTEX_BITS;
	localparam int CB = ctom_pkg::CORNER_BITS;
	localparam int AW = $clog2(EDGE_SLOTS);
	localparam int PW = $clog2(EDGE_SLOTS + 1);
	localparam int TW = $clog2(MAX_TRIANGLES + 1);
	localparam int EW = 2 + 2 * V + CB;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_START = 4'd3;
	localparam logic [3:0] S_PROBE = 4'd4;
	localparam logic [3:0] S_EVAL  = 4'd5;
	localparam logic [3:0] S_EMIT  = 4'd6;
	localparam logic [3:0] S_NEXTK = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [EW-1:0] mem [EDGE_SLOTS];
	logic [EW-1:0] rdata_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	logic [3:0]    state_q;
	logic          clr_ret_q;
	logic [AW-1:0] clr_addr_q;
	logic [V-1:0]  va_q, vb_q, vc_q;
	logic [1:0]    k_q;
	logic [TW-1:0] tri_cnt_q;
	logic [CB-1:0] base_q;
	logic [PW-1:0] pend_q;
	logic [AW-1:0] idx_q;
	logic [PW-1:0] n_q;
	logic          ins_have_q;
	logic [AW-1:0] ins_idx_q;
	logic [V-1:0]  from_q, to_q;
	ctom_pkg::result_t res_q, nres_q;
	logic          have_q;

	logic [V-1:0]  from_c, to_c;
	logic [V:0]    sum_c;
	logic [AW-1:0] fold_c;
	logic [AW-1:0] hash_c;
	logic [CB-1:0] corner_c;
	logic [1:0]    e_st;
	logic [V-1:0]  e_from, e_to;
	logic [CB-1:0] e_corner;
	logic          e_used, e_match, e_ok, e_stop;
	logic [AW-1:0] idx_next;
	logic          full;
	logic          push_ok;

	assign corner_c = base_q + CB'(k_q);
	assign {e_st, e_from, e_to, e_corner} = rdata_q;
	assign e_used   = (e_st == ctom_pkg::SLOT_USED);
	assign e_ok     = (e_from == to_q) && (e_to == from_q);
	assign e_match  = e_used && (e_ok || ((e_from == from_q) && (e_to == to_q)));
	assign e_stop   = (e_st == ctom_pkg::SLOT_EMPTY) || (n_q == PW'(EDGE_SLOTS - 1));
	assign idx_next = (idx_q == AW'(EDGE_SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign full     = (pend_q >= PW'(EDGE_SLOTS));
	assign push_ok  = !have_q || res_ready;
	assign clearing = (state_q == S_CLR);

	// edge faced by corner k: next vertex to previous vertex
	always_comb begin
		case (k_q)
			2'd0: begin from_c = vb_q; to_c = vc_q; end
			2'd1: begin from_c = vc_q; to_c = va_q; end
			default: begin from_c = va_q; to_c = vb_q; end
		endcase
		sum_c  = {1'b0, from_c} + {1'b0, to_c};
		fold_c = '0;
		for (int i = 0; i <= V; i++)
			fold_c[i % AW] = fold_c[i % AW] ^ sum_c[i];
		if ({1'b0, fold_c} >= (AW + 1)'(EDGE_SLOTS))
			hash_c = fold_c - AW'(EDGE_SLOTS);
		else
			hash_c = fold_c;
	end

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = have_q && ((state_q == S_EMIT) || (state_q == S_FIN));
	always_comb begin
		res      = res_q;
		res.last = (state_q == S_FIN);
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
		end else if (state_q == S_EVAL) begin
			if (e_match) begin
				we    = 1'b1;
				wdata = {ctom_pkg::SLOT_TOMB, e_from, e_to, e_corner};
			end else if (e_stop && !full) begin
				we    = 1'b1;
				waddr = ins_have_q ? ins_idx_q : idx_q;
				wdata = {ctom_pkg::SLOT_USED, from_q, to_q, corner_c};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_ret_q  <= 1'b0;
			clr_addr_q <= '0;
			k_q        <= '0;
			tri_cnt_q  <= '0;
			base_q     <= '0;
			pend_q     <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			ins_have_q <= 1'b0;
			have_q     <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(EDGE_SLOTS - 1)) begin
						clr_addr_q <= '0;
						tri_cnt_q  <= '0;
						base_q     <= '0;
						pend_q     <= '0;
						state_q    <= clr_ret_q ? S_CHECK : S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						clr_ret_q <= 1'b1;
						state_q   <= item.new_mesh ? S_CLR : S_CHECK;
					end
				end
				S_CHECK: begin
					k_q <= '0;
					if (tri_cnt_q >= TW'(MAX_TRIANGLES)) begin
						have_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_START;
					end
				end
				S_START: begin
					idx_q      <= hash_c;
					n_q        <= '0;
					ins_have_q <= 1'b0;
					state_q    <= S_PROBE;
				end
				S_PROBE: state_q <= S_EVAL;
				S_EVAL: begin
					if (e_match) begin
						pend_q  <= pend_q - 1'b1;
						state_q <= S_EMIT;
					end else if (e_stop) begin
						if (full) begin
							state_q <= S_EMIT;
						end else begin
							pend_q  <= pend_q + 1'b1;
							state_q <= S_NEXTK;
						end
					end else begin
						if (!e_used && !ins_have_q) begin
							ins_have_q <= 1'b1;
							ins_idx_q  <= idx_q;
						end
						idx_q   <= idx_next;
						n_q     <= n_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_EMIT: begin
					// flush the held result, keep the new one until we know if it is last
					if (push_ok) begin
						have_q  <= 1'b1;
						state_q <= S_NEXTK;
					end
				end
				S_NEXTK: begin
					if (k_q == 2'd2) begin
						tri_cnt_q <= tri_cnt_q + 1'b1;
						base_q    <= base_q + CB'(3);
						state_q   <= S_FIN;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_START;
					end
				end
				S_FIN: begin
					if (push_ok) begin
						have_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			va_q <= V'({8'd0, item.vertex_a});
			vb_q <= V'({8'd0, item.vertex_b});
			vc_q <= V'({8'd0, item.vertex_c});
		end
		if (state_q == S_START) begin
			from_q <= from_c;
			to_q   <= to_c;
		end
		if (state_q == S_CHECK)
			res_q <= '{corner_id: '0, opposite_id: '0,
				status: ctom_pkg::STATUS_TOO_MANY, last: 1'b0};
		if (state_q == S_EMIT && push_ok)
			res_q <= nres_q;
		if (state_q == S_EVAL) begin
			if (e_match)
				nres_q <= '{corner_id: corner_c, opposite_id: e_corner,
					status: e_ok ? ctom_pkg::STATUS_MATCH : ctom_pkg::STATUS_FLIPPED,
					last: 1'b0};
			else
				nres_q <= '{corner_id: corner_c, opposite_id: '0,
					status: ctom_pkg::STATUS_FULL, last: 1'b0};
		end
	end
endmodule
`default_nettype wire

>>> hdl/corner_table_opposite_matcher_unit.sv
// Top level of the corner table opposite matcher.
// Depends on ctom_pkg, ctom_if, ctom_fifo and ctom_engine.
//
// Takes one triangle per item and returns, for each of its three corners that
// closes an edge already seen, the corner and its opposite corner; corners that
// open a new edge are stored and return nothing, and a corner that finds the
// memory full returns a FULL result. An item past the triangle limit returns a
// single TOO_MANY result. Each corner hashes its vertex pair into a pending-edge
// memory of EDGE_SLOTS entries and probes it with linear probing. After reset
// and on every new_mesh item the memory is swept once, during which no item is
// taken. Two-entry queues on the input and output let both sides stall on
// their own.
`default_nettype none
module corner_table_opposite_matcher_unit #(
	parameter int MAX_TRIANGLES = 4096,
	parameter int VERTEX_BITS   = 16,
	parameter int EDGE_SLOTS    = 1024
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ctom_in_if.sink    triangles,
	ctom_out_if.source results
);
	localparam int IW = $bits(ctom_pkg::tri_item_t);
	localparam int RW = $bits(ctom_pkg::result_t);

	ctom_pkg::tri_item_t in_item, q_item;
	ctom_pkg::result_t   eng_res, out_res;
	logic                q_valid, q_ready, fifo_ready;
	logic                r_valid, r_ready;
	logic                clearing;

	assign in_item = '{new_mesh: triangles.new_mesh, vertex_a: triangles.vertex_a,
		vertex_b: triangles.vertex_b, vertex_c: triangles.vertex_c};
	assign triangles.ready = fifo_ready && !clearing;

	ctom_fifo #(.WIDTH(IW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push_valid(triangles.valid && !clearing), .push_ready(fifo_ready),
		.push_data(in_item),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_item)
	);

	ctom_engine #(
		.MAX_TRIANGLES(MAX_TRIANGLES), .VERTEX_BITS(VERTEX_BITS), .EDGE_SLOTS(EDGE_SLOTS)
	) u_engine (
		.clk(clk), .arst_n(arst_n),
		.item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.res_valid(r_valid), .res_ready(r_ready), .res(eng_res),
		.clearing(clearing)
	);

	ctom_fifo #(.WIDTH(RW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.push_valid(r_valid), .push_ready(r_ready), .push_data(eng_res),
		.pop_valid(results.valid), .pop_ready(results.ready), .pop_data(out_res)
	);

	assign results.corner_id   = out_res.corner_id;
	assign results.opposite_id = out_res.opposite_id;
	assign results.status      = out_res.status;
	assign results.last        = out_res.last;
endmodule
`default_nettype wire

>>> hdl/ctom_checker.sv
// Port-level checks for the corner table opposite matcher, bound to the top level.
// Depends on ctom_pkg.
`default_nettype none
module ctom_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             valid,
	input wire logic                             ready,
	input wire logic [ctom_pkg::CORNER_BITS-1:0] corner_id,
	input wire logic [ctom_pkg::CORNER_BITS-1:0] opposite_id,
	input wire logic [1:0]                       status,
	input wire logic                             last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result dropped while stalled");

	a_err_opp: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == ctom_pkg::STATUS_FULL || status == ctom_pkg::STATUS_TOO_MANY)
		|-> opposite_id == '0)
		else $error("error result carries an opposite corner");

	a_too_many: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ctom_pkg::STATUS_TOO_MANY |-> last && corner_id == '0)
		else $error("overflow result is malformed");
endmodule

bind corner_table_opposite_matcher_unit ctom_checker u_ctom_checker (
	.clk(clk), .arst_n(arst_n),
	.valid(results.valid), .ready(results.ready),
	.corner_id(results.corner_id), .opposite_id(results.opposite_id),
	.status(results.status), .last(results.last)
);
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for corner_table_opposite_matcher_unit: drives triangle items, predicts
// the opposite-corner results with its own pending-edge table, and checks each result item.
// Depends on ctom_pkg, ctom_if and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int MAX_TRI = 4096;
	localparam int SLOTS   = 1024;
	localparam longint CYCLE_LIMIT = 20000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	ctom_in_if  tri_ch ();
	ctom_out_if res_ch ();

	corner_table_opposite_matcher_unit uut (
		.clk(clk), .arst_n(arst_n), .triangles(tri_ch.sink), .results(res_ch.source)
	);

	// predictor state
	typedef struct {
		bit        used;
		bit [15:0] from_v;
		bit [15:0] to_v;
		bit [13:0] corner;
	} slot_t;
	slot_t             pend_tab[SLOTS];
	int                pend_cnt;
	int                tri_cnt;
	ctom_pkg::result_t expected_q[$];

	int  mismatches = 0;
	bit  sink_idle_on = 1'b1;
	bit  src_idle_on = 1'b1;
	longint cycles = 0;

	function automatic void clear_mesh_model();
		foreach (pend_tab[i]) pend_tab[i].used = 1'b0;
		pend_cnt = 0;
		tri_cnt = 0;
	endfunction

	function automatic void queue_expect(ctom_pkg::result_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void predict_corners(bit nm, bit [15:0] va, bit [15:0] vb,
			bit [15:0] vc);
		bit [15:0] vtx[3];
		bit [15:0] f;
		bit [15:0] t;
		int hit;
		int n;
		int base;
		ctom_pkg::result_t r;
		if (nm) clear_mesh_model();
		if (tri_cnt >= MAX_TRI) begin
			r = '{corner_id: '0, opposite_id: '0, status: ctom_pkg::STATUS_TOO_MANY,
				last: 1'b1};
			queue_expect(r);
			return;
		end
		vtx[0] = va; vtx[1] = vb; vtx[2] = vc;
		base = 3 * tri_cnt;
		n = 0;
		for (int k = 0; k < 3; k++) begin
			f = vtx[(k + 1) % 3];
			t = vtx[(k + 2) % 3];
			hit = -1;
			for (int s = 0; s < SLOTS; s++) begin
				if (pend_tab[s].used && ((pend_tab[s].from_v == f && pend_tab[s].to_v == t) ||
						(pend_tab[s].from_v == t && pend_tab[s].to_v == f))) begin
					hit = s;
					break;
				end
			end
			if (hit >= 0) begin
				r.corner_id = 14'(base + k);
				r.opposite_id = pend_tab[hit].corner;
				r.status = (pend_tab[hit].from_v == t && pend_tab[hit].to_v == f) ?
					ctom_pkg::STATUS_MATCH : ctom_pkg::STATUS_FLIPPED;
				r.last = 1'b0;
				queue_expect(r);
				n++;
				pend_tab[hit].used = 1'b0;
				pend_cnt--;
			end else if (pend_cnt >= SLOTS) begin
				r = '{corner_id: 14'(base + k), opposite_id: '0,
					status: ctom_pkg::STATUS_FULL, last: 1'b0};
				queue_expect(r);
				n++;
			end else begin
				for (int s = 0; s < SLOTS; s++) begin
					if (!pend_tab[s].used) begin
						pend_tab[s] = '{1'b1, f, t, 14'(base + k)};
						pend_cnt++;
						break;
					end
				end
			end
		end
		tri_cnt++;
		if (n > 0) expected_q[$].last = 1'b1;
	endfunction

	// send one triangle; when enabled, sometimes drop valid for an idle burst ahead of it
	task automatic send_triangle(bit nm, bit [15:0] va, bit [15:0] vb, bit [15:0] vc);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			tri_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		tri_ch.valid <= 1'b1;
		tri_ch.new_mesh <= nm;
		tri_ch.vertex_a <= va;
		tri_ch.vertex_b <= vb;
		tri_ch.vertex_c <= vc;
		do @(posedge clk); while (!tri_ch.ready);
		predict_corners(nm, va, vb, vc);
	endtask

	// result sink: random stall bursts, compare against oldest expectation
	int stall_left = 0;
	always @(posedge clk) begin
		ctom_pkg::result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result corner=%0d opp=%0d status=%0d last=%0d",
						res_ch.corner_id, res_ch.opposite_id, res_ch.status, res_ch.last);
			end else begin
				want = expected_q.pop_front();
				if (want.corner_id !== res_ch.corner_id || want.opposite_id !== res_ch.opposite_id
						|| want.status !== res_ch.status || want.last !== res_ch.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp c=%0d o=%0d s=%0d l=%0d got c=%0d o=%0d s=%0d l=%0d",
							want.corner_id, want.opposite_id, want.status, want.last,
							res_ch.corner_id, res_ch.opposite_id, res_ch.status, res_ch.last);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic drain_results();
		tri_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic bit [15:0] rand_vtx(int span);
		return 16'($urandom_range(0, span));
	endfunction

	task automatic test_directed();
		// field extremes and a consistent shared edge
		send_triangle(1'b1, 16'h0000, 16'hFFFF, 16'h5555);
		send_triangle(1'b0, 16'hFFFF, 16'h0000, 16'hAAAA);
		// same triangle in reverse winding: each edge matches with consistent orientation
		send_triangle(1'b0, 16'h0000, 16'hFFFF, 16'h1234);
		send_triangle(1'b0, 16'h1234, 16'hFFFF, 16'h0000);
		// degenerate triangles matching their own edges
		send_triangle(1'b0, 16'h0007, 16'h0007, 16'h0007);
		send_triangle(1'b0, 16'h0009, 16'h0009, 16'h000A);
		// all corners store, no result
		send_triangle(1'b0, 16'h0100, 16'h0200, 16'h0300);
		// new mesh drops pending edges
		send_triangle(1'b1, 16'h0200, 16'h0100, 16'h0301);
		send_triangle(1'b0, 16'h0100, 16'h0200, 16'h0302);
		drain_results();
	endtask

	task automatic test_table_full();
		// each triangle with fresh vertices stores an edge for each of its corners until the table fills
		send_triangle(1'b1, 16'd0, 16'd1, 16'd2);
		for (int i = 1; i < 345; i++)
			send_triangle(1'b0, 16'(3 * i), 16'(3 * i + 1), 16'(3 * i + 2));
		// two corners find the table full, then the last corner still hits a pending edge
		send_triangle(1'b0, 16'd1, 16'd0, 16'd40000);
		drain_results();
	endtask

	task automatic test_random_meshes();
		int span;
		bit nm;
		for (int i = 0; i < 105; i++) begin
			if (i == 85) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			nm = (i % 60 == 0) || ($urandom_range(0, 99) == 0);
			// mostly a small vertex pool so edges get shared; sometimes the full range
			span = ($urandom_range(0, 9) == 0) ? 65535 : 12;
			if (span == 65535)
				send_triangle(nm, rand_vtx(span), rand_vtx(span), rand_vtx(span));
			else
				send_triangle(nm, 16'hFFF0 ^ rand_vtx(span), 16'hFFF0 ^ rand_vtx(span),
					16'hFFF0 ^ rand_vtx(span));
		end
		drain_results();
	endtask

	initial begin
		tri_ch.valid = 1'b0;
		tri_ch.new_mesh = 1'b0;
		tri_ch.vertex_a = '0;
		tri_ch.vertex_b = '0;
		tri_ch.vertex_c = '0;
		res_ch.ready = 1'b0;
		clear_mesh_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_table_full();
		test_random_meshes();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
hdl/ctom_pkg.sv
hdl/ctom_if.sv
hdl/ctom_fifo.sv
hdl/ctom_engine.sv
hdl/corner_table_opposite_matcher_unit.sv
hdl/ctom_checker.sv
dv/tb_top.sv
